### sv/lerr_pkg.sv
package lerr_pkg;

    // Default ring depth in bytes.
    localparam int RING_DEPTH_DEF = 16;

    // Character width and the widths of the stream data buses.
    localparam int BYTE_W    = 8;
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 24;

    // Configuration port geometry.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Register indexes and their byte addresses.
    localparam int REG_ECHO_SUPPRESS = 0;
    localparam logic [PADDR_W-1:0] ADDR_ECHO_SUPPRESS = PADDR_W'(4 * REG_ECHO_SUPPRESS);

    // Input kinds carried on tuser.
    localparam logic KIND_RX_BYTE = 1'b0;
    localparam logic KIND_EXTRACT = 1'b1;

    // Special characters.
    localparam logic [BYTE_W-1:0] CH_BREAK = 8'h03;
    localparam logic [BYTE_W-1:0] CH_BS    = 8'h08;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;

    // One result word as it leaves the sequencer.
    typedef struct packed {
        logic              echo_valid;
        logic [BYTE_W-1:0] echo_byte;
        logic              break_event;
        logic              overflow_event;
        logic              line_found;
        logic [BYTE_W-1:0] line_byte;
        logic              last;
    } t_result;

endpackage

### sv/lerr_ring.sv
module lerr_ring #(
    parameter int RING_DEPTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_wr_en,
    input  logic [$clog2(RING_DEPTH)-1:0] i_wr_addr,
    input  logic [7:0]                    i_wr_data,
    input  logic                          i_rd_en,
    input  logic [$clog2(RING_DEPTH)-1:0] i_rd_addr,
    output logic [7:0]                    o_rd_data
);
    import lerr_pkg::*;

    logic [BYTE_W-1:0] r_mem [RING_DEPTH];
    logic [BYTE_W-1:0] r_rd_data;

    // Single write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port; the data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### sv/lerr_step.sv
module lerr_step #(
    parameter int RING_DEPTH = 16
) (
    input  logic [$clog2(RING_DEPTH)-1:0] i_idx,
    input  logic                          i_back,
    output logic [$clog2(RING_DEPTH)-1:0] o_idx
);
    import lerr_pkg::*;

    localparam int IW = $clog2(RING_DEPTH);
    localparam logic [IW-1:0] TOP_IDX = IW'(RING_DEPTH - 1);

    // Shared ring index stepper: one slot forward or back, with wrap.
    always_comb begin
        if (i_back) begin
            o_idx = (i_idx == '0) ? TOP_IDX : i_idx - 1'b1;
        end else begin
            o_idx = (i_idx == TOP_IDX) ? '0 : i_idx + 1'b1;
        end
    end

endmodule

### sv/lerr_ctrl.sv
module lerr_ctrl #(
    parameter int RING_DEPTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_kind,
    input  logic [7:0]                    i_byte,
    input  logic                          i_echo_suppress,
    input  logic                          i_out_free,
    output logic                          o_res_load,
    output lerr_pkg::t_result             o_res,
    output logic                          o_wr_en,
    output logic [$clog2(RING_DEPTH)-1:0] o_wr_addr,
    output logic [7:0]                    o_wr_data,
    output logic                          o_rd_en,
    output logic [$clog2(RING_DEPTH)-1:0] o_rd_addr,
    input  logic [7:0]                    i_rd_data
);
    import lerr_pkg::*;

    localparam int IW = $clog2(RING_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_BYTE,
        S_SCAN,
        S_SCAN_CHK,
        S_EMIT_RD,
        S_EMIT_WR,
        S_TERM,
        S_MISS
    } t_state;

    t_state            r_state, n_state;
    logic [IW-1:0]     r_widx, n_widx;
    logic [IW-1:0]     r_ridx, n_ridx;
    logic [IW-1:0]     r_p, n_p;
    logic [IW-1:0]     r_q, n_q;
    logic              r_kind, n_kind;
    logic [BYTE_W-1:0] r_byte, n_byte;

    logic [IW-1:0]     st_in;
    logic              st_back;
    logic [IW-1:0]     st_out;

    // The one index stepper, shared by the byte, scan-check, emit and terminator states.
    lerr_step #(
        .RING_DEPTH (RING_DEPTH)
    ) u_step (
        .i_idx  (st_in),
        .i_back (st_back),
        .o_idx  (st_out)
    );

    // Stepper operand: the write pointer while storing, the scan or emit
    // pointer during extraction.
    always_comb begin
        st_back = 1'b0;
        case (r_state)
            S_BYTE: begin
                st_in   = r_widx;
                st_back = (r_byte == CH_BS);
            end
            S_SCAN_CHK, S_TERM: st_in = r_p;
            S_EMIT_WR:          st_in = r_q;
            default:            st_in = r_widx;
        endcase
    end

    // Sequencer next-state and datapath control.
    always_comb begin
        n_state    = r_state;
        n_widx     = r_widx;
        n_ridx     = r_ridx;
        n_p        = r_p;
        n_q        = r_q;
        n_kind     = r_kind;
        n_byte     = r_byte;
        o_in_ready = 1'b0;
        o_res_load = 1'b0;
        o_res      = '0;
        o_wr_en    = 1'b0;
        o_wr_addr  = r_widx;
        o_wr_data  = r_byte;
        o_rd_en    = 1'b0;
        o_rd_addr  = (r_state == S_SCAN) ? r_p : r_q;

        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_kind  = i_kind;
                    n_byte  = i_byte;
                    n_p     = r_ridx;
                    n_state = (i_kind == KIND_EXTRACT) ? S_SCAN : S_BYTE;
                end
            end

            // Received byte: store, edit or flag, and give one word.
            S_BYTE: begin
                if (i_out_free) begin
                    o_res_load = 1'b1;
                    o_res.last = 1'b1;
                    n_state    = S_IDLE;
                    if (r_byte == CH_BREAK) begin
                        o_res.break_event = 1'b1;
                    end else begin
                        o_res.echo_valid = !i_echo_suppress;
                        o_res.echo_byte  = i_echo_suppress ? '0 : r_byte;
                        o_wr_en          = 1'b1;
                        if (r_byte == CH_BS) begin
                            o_wr_data = CH_SPACE;
                            if (r_widx != r_ridx) begin
                                n_widx    = st_out;
                                o_wr_addr = st_out;
                            end
                        end else if (st_out == r_ridx) begin
                            o_res.overflow_event = 1'b1;
                        end else begin
                            n_widx = st_out;
                        end
                    end
                end
            end

            // Look for carriage return, one slot per read.
            S_SCAN: begin
                if (r_p == r_widx) begin
                    n_state = S_MISS;
                end else begin
                    o_rd_en = 1'b1;
                    n_state = S_SCAN_CHK;
                end
            end

            S_SCAN_CHK: begin
                if (i_rd_data == CH_CR) begin
                    n_q     = r_ridx;
                    n_state = S_EMIT_RD;
                end else begin
                    n_p     = st_out;
                    n_state = S_SCAN;
                end
            end

            // Read the line back out up to the carriage return.
            S_EMIT_RD: begin
                if (r_q == r_p) begin
                    n_state = S_TERM;
                end else begin
                    o_rd_en = 1'b1;
                    n_state = S_EMIT_WR;
                end
            end

            S_EMIT_WR: begin
                if (i_out_free) begin
                    o_res_load       = 1'b1;
                    o_res.line_found = 1'b1;
                    o_res.line_byte  = i_rd_data;
                    n_q              = st_out;
                    n_state          = S_EMIT_RD;
                end
            end

            // Terminator word, then consume the line and its carriage return.
            S_TERM: begin
                if (i_out_free) begin
                    o_res_load       = 1'b1;
                    o_res.line_found = 1'b1;
                    o_res.last       = 1'b1;
                    n_ridx           = st_out;
                    n_state          = S_IDLE;
                end
            end

            S_MISS: begin
                if (i_out_free) begin
                    o_res_load = 1'b1;
                    o_res.last = 1'b1;
                    n_state    = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // State and pointer registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_widx  <= '0;
            r_ridx  <= '0;
        end else begin
            r_state <= n_state;
            r_widx  <= n_widx;
            r_ridx  <= n_ridx;
        end
        r_p    <= n_p;
        r_q    <= n_q;
        r_kind <= n_kind;
        r_byte <= n_byte;
    end

    // A word is only handed over when the output register can take it.
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_load |-> i_out_free)
        else $error("result loaded into a full output register");

    // The last word of an item returns the sequencer to idle.
    a_last_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_load && o_res.last) |=> (r_state == S_IDLE))
        else $error("sequencer busy after the last word");

    // The read pointer moves only when a line is consumed.
    a_ridx_on_term: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$stable(r_ridx)) |-> ($past(r_state) == S_TERM))
        else $error("read pointer moved outside line consumption");

    // The write pointer moves only while a received byte is handled.
    a_widx_on_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$stable(r_widx)) |-> ($past(r_state) == S_BYTE))
        else $error("write pointer moved outside byte handling");

    // An extraction never stores into the ring.
    a_no_write_on_extract: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_wr_en |-> (r_kind == KIND_RX_BYTE)))
        else $error("ring written during extraction");

endmodule

### sv/line_edit_receive_ring.sv
// Receive line editor for a serial terminal, built on a ring of RING_DEPTH bytes.
// Input stream: s_tdata carries the received character and s_tuser the kind of
// word (0 = received character, 1 = request to extract one line).
// Output stream: one word per result, m_tlast marks the final word of an item.
// A received character gives exactly one word (echo, break or overflow flags).
// An extract request scans the ring from the read pointer for carriage return,
// one ring read and one compare per slot, then reads the line back out byte by
// byte and ends with a zero terminator. The ring has a single read port.
// One item is worked on at a time and s_tready is low until its last word is
// in the output register.
// The output register lets the block accept the next word while the last result
// waits; if the receiver stalls, the sequencer holds until that register frees.
// Reset empties the ring (both pointers to zero) and clears echo_suppress; the
// ring contents are not cleared. echo_suppress sits at byte address 0 of the
// register port; the user writes it only while the block is idle (not enforced).
module line_edit_receive_ring #(
    parameter int RING_DEPTH = lerr_pkg::RING_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [lerr_pkg::S_TDATA_W-1:0] s_tdata,  // [7:0] rx_byte
    input  logic                           s_tuser,  // [0] kind
    // Output stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [0] echo_valid, [8:1] echo_byte, [9] break_event, [10] overflow_event,
    // [11] line_found, [19:12] line_byte, [23:20] zero
    output logic [lerr_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                           m_tlast,  // last
    // Register port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lerr_pkg::PADDR_W-1:0]   paddr,
    input  logic [lerr_pkg::PDATA_W-1:0]   pwdata,
    output logic [lerr_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready
);
    import lerr_pkg::*;

    localparam int IW = $clog2(RING_DEPTH);

    logic              r_echo_suppress;
    logic              r_out_valid;
    t_result           r_out;

    logic              out_free;
    logic              res_load;
    t_result           res;
    logic              wr_en;
    logic [IW-1:0]     wr_addr;
    logic [BYTE_W-1:0] wr_data;
    logic              rd_en;
    logic [IW-1:0]     rd_addr;
    logic [BYTE_W-1:0] rd_data;

    // Register port: always ready, one register.
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_ECHO_SUPPRESS) ? PDATA_W'(r_echo_suppress) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_echo_suppress <= 1'b0;
        end else if (psel && penable && pwrite && pready
                     && (paddr == ADDR_ECHO_SUPPRESS)) begin
            r_echo_suppress <= pwdata[0];
        end
    end

    // Sequencer and ring.
    lerr_ctrl #(
        .RING_DEPTH (RING_DEPTH)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (s_tvalid),
        .o_in_ready      (s_tready),
        .i_kind          (s_tuser),
        .i_byte          (s_tdata[BYTE_W-1:0]),
        .i_echo_suppress (r_echo_suppress),
        .i_out_free      (out_free),
        .o_res_load      (res_load),
        .o_res           (res),
        .o_wr_en         (wr_en),
        .o_wr_addr       (wr_addr),
        .o_wr_data       (wr_data),
        .o_rd_en         (rd_en),
        .o_rd_addr       (rd_addr),
        .i_rd_data       (rd_data)
    );

    lerr_ring #(
        .RING_DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Output register: free when empty or being taken this cycle.
    assign out_free = !r_out_valid || m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= res_load;
        end
        if (out_free && res_load) begin
            r_out <= res;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tlast  = r_out.last;
    assign m_tdata  = {4'b0000, r_out.line_byte, r_out.line_found, r_out.overflow_event,
                       r_out.break_event, r_out.echo_byte, r_out.echo_valid};

endmodule
